>>> rtl/bilp_pkg.sv
// ----------------------------------------------------------------------------
// Binary image load parser package
// Shared item and result types, parser phases and result codes.
// ----------------------------------------------------------------------------
package bilp_pkg;

  localparam int unsigned PhaseW = 5;

  // Marker bytes of the two image formats.
  localparam logic [7:0] FmtAMark  = 8'h00;
  localparam logic [7:0] FmtBMark  = 8'h55;
  localparam logic [7:0] ChunkData = 8'h00;
  localparam logic [7:0] ChunkEnd  = 8'hFF;

  typedef enum logic [PhaseW-1:0] {
    PhIdle,
    PhATypeB,
    PhALenH,
    PhALenL,
    PhAAddrH,
    PhAAddrL,
    PhAData,
    PhAPost0,
    PhAPost1,
    PhAPost2,
    PhAPost3,
    PhBFtype,
    PhBLoadH,
    PhBLoadL,
    PhBLenH,
    PhBLenL,
    PhBExecH,
    PhBExecL,
    PhBTrail,
    PhBData,
    PhBPend
  } phase_e;

  typedef enum logic [1:0] {
    KindWrite,
    KindDone,
    KindError
  } kind_e;

  typedef enum logic [3:0] {
    ErrEmpty,
    ErrUnknownFmt,
    ErrTruncated,
    ErrNoPostamble,
    ErrShortHeader,
    ErrShortPayload,
    ErrTooManyBlocks,
    ErrShortPostamble,
    ErrNoBlocks,
    ErrBadChunk,
    ErrShortBHeader
  } err_e;

  typedef struct packed {
    logic       mode;
    logic       new_file;
    logic [7:0] byte_value;
  } item_t;

  typedef struct packed {
    kind_e       result_kind;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic [15:0] exec_address;
    logic        format_kind;
    err_e        error_code;
    logic [12:0] block_count;
  } result_t;

endpackage

>>> rtl/bilp_stage.sv
// ----------------------------------------------------------------------------
// Pipeline register stage
// One-entry valid/ready register; takes a new request while the held one
// is being drained, so it sustains one request per cycle while ready_i is high.
// ----------------------------------------------------------------------------
module bilp_stage #(
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [DATA_W-1:0] data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [DATA_W-1:0] data_o
);

  logic              valid_q;
  logic              valid_d;
  logic [DATA_W-1:0] data_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_d = (valid_i && ready_o) || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> rtl/bilp_parser.sv
// ----------------------------------------------------------------------------
// Image parser core
// Phase register and header fields; decodes one byte or end mark per cycle
// while take_i is high and produces at most one result for it.
// ----------------------------------------------------------------------------
module bilp_parser
  import bilp_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 4096
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    take_i,
  input  item_t   item_i,
  output logic    res_valid_o,
  output result_t res_o
);

  localparam int unsigned CntW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned ExtW = (CntW > 13) ? CntW : 13;

  phase_e            phase_q, phase_d;
  logic              fmt_q, fmt_d;
  logic [7:0]        hold_q, hold_d;
  logic [15:0]       rem_q, rem_d;
  logic [15:0]       load_q, load_d;
  logic [15:0]       entry_q, entry_d;
  logic [CntW-1:0]   blocks_q, blocks_d;
  logic              room;
  logic [CntW-1:0]   blocks_inc;
  logic [15:0]       word;
  logic [ExtW-1:0]   blocks_ext;
  logic              res_vld;
  kind_e             res_kind;
  logic [15:0]       res_addr;
  logic [7:0]        res_data;
  logic              res_exec_sel;
  err_e              res_err;
  logic [7:0]        b;

  assign b          = item_i.byte_value;
  assign room       = blocks_q < CntW'(MAX_BLOCKS);
  assign blocks_inc = blocks_q + CntW'(1);
  assign word       = {hold_q, b};

  always_comb begin
    phase_d      = phase_q;
    fmt_d        = fmt_q;
    hold_d       = hold_q;
    rem_d        = rem_q;
    load_d       = load_q;
    entry_d      = entry_q;
    blocks_d     = blocks_q;
    res_vld      = 1'b0;
    res_kind     = KindWrite;
    res_addr     = '0;
    res_data     = '0;
    res_exec_sel = 1'b0;
    res_err      = ErrEmpty;

    if (item_i.new_file) begin
      // A new file restarts everything; its first byte is also format A's
      // first chunk type.
      phase_d  = PhIdle;
      fmt_d    = 1'b0;
      hold_d   = '0;
      rem_d    = '0;
      load_d   = '0;
      entry_d  = '0;
      blocks_d = '0;
      if (item_i.mode) begin
        res_vld = 1'b1;
        res_kind = KindError;
        res_err = ErrEmpty;
      end else if (b == FmtAMark) begin
        phase_d = PhALenH;
      end else if (b == FmtBMark) begin
        fmt_d   = 1'b1;
        phase_d = PhBFtype;
      end else begin
        res_vld = 1'b1;
        res_kind = KindError;
        res_err = ErrUnknownFmt;
      end
    end else if (item_i.mode) begin
      unique case (phase_q)
        PhATypeB: begin
          res_vld  = 1'b1;
          res_kind = KindError;
          res_err  = (blocks_q == '0) ? ErrTruncated : ErrNoPostamble;
        end
        PhALenH, PhALenL, PhAAddrH, PhAAddrL: begin
          res_vld = 1'b1; res_kind = KindError; res_err = ErrShortHeader;
        end
        PhAData, PhBData: begin
          res_vld = 1'b1; res_kind = KindError; res_err = ErrShortPayload;
        end
        PhAPost0, PhAPost1, PhAPost2, PhAPost3: begin
          res_vld = 1'b1; res_kind = KindError; res_err = ErrShortPostamble;
        end
        PhBFtype, PhBLoadH, PhBLoadL, PhBLenH, PhBLenL, PhBExecH, PhBExecL: begin
          res_vld = 1'b1; res_kind = KindError; res_err = ErrShortBHeader;
        end
        PhBTrail: begin
          res_vld = 1'b1;
          if (rem_q != '0) begin
            res_kind = KindError; res_err = ErrShortPayload;
          end else if (!room) begin
            res_kind = KindError; res_err = ErrTooManyBlocks;
          end else begin
            blocks_d = blocks_inc;
            res_kind = KindDone; res_exec_sel = 1'b1;
          end
        end
        PhBPend: begin
          res_vld = 1'b1; res_kind = KindDone; res_exec_sel = 1'b1;
        end
        default: ;
      endcase
      if (res_vld) begin
        phase_d = PhIdle;
      end
    end else begin
      unique case (phase_q)
        PhATypeB: begin
          if (b == ChunkData) begin
            phase_d = PhALenH;
          end else if (b == ChunkEnd) begin
            phase_d = PhAPost0;
          end else begin
            res_vld = 1'b1; res_kind = KindError; res_err = ErrBadChunk;
          end
        end
        PhALenH, PhAAddrH, PhAPost2, PhBLoadH, PhBLenH, PhBExecH: begin
          hold_d  = b;
          phase_d = phase_e'(PhaseW'(phase_q) + PhaseW'(1));
        end
        PhAPost0, PhAPost1, PhBFtype: begin
          phase_d = phase_e'(PhaseW'(phase_q) + PhaseW'(1));
        end
        PhALenL: begin
          rem_d = word; phase_d = PhAAddrH;
        end
        PhAAddrL: begin
          load_d = word;
          if (rem_q != '0) begin
            phase_d = PhAData;
          end else if (!room) begin
            res_vld = 1'b1; res_kind = KindError; res_err = ErrTooManyBlocks;
          end else begin
            blocks_d = blocks_inc;
            phase_d  = PhATypeB;
          end
        end
        PhAData, PhBData: begin
          load_d   = load_q + 16'd1;
          rem_d    = rem_q - 16'd1;
          res_vld  = 1'b1;
          res_kind = KindWrite;
          res_addr = load_q;
          res_data = b;
          if (rem_d == '0) begin
            // The last byte of a block over the limit reports the error
            // in place of its write.
            if (!room) begin
              res_kind = KindError;
              res_addr = '0;
              res_data = '0;
              res_err  = ErrTooManyBlocks;
            end else begin
              blocks_d = blocks_inc;
              phase_d  = (phase_q == PhAData) ? PhATypeB : PhBPend;
            end
          end
        end
        PhAPost3: begin
          entry_d = word;
          res_vld = 1'b1;
          if (blocks_q == '0) begin
            res_kind = KindError; res_err = ErrNoBlocks;
          end else begin
            res_kind = KindDone; res_exec_sel = 1'b1;
          end
        end
        PhBLoadL: begin
          load_d = word; phase_d = PhBLenH;
        end
        PhBLenL: begin
          rem_d = word; phase_d = PhBExecH;
        end
        PhBExecL: begin
          entry_d = word; phase_d = PhBTrail;
        end
        PhBTrail: begin
          if (rem_q != '0) begin
            phase_d = PhBData;
          end else if (!room) begin
            res_vld = 1'b1; res_kind = KindError; res_err = ErrTooManyBlocks;
          end else begin
            blocks_d = blocks_inc;
            res_vld  = 1'b1; res_kind = KindDone; res_exec_sel = 1'b1;
          end
        end
        PhBPend: begin
          res_vld = 1'b1; res_kind = KindDone; res_exec_sel = 1'b1;
        end
        default: ;
      endcase
      if (res_vld && res_kind != KindWrite) begin
        phase_d = PhIdle;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      fmt_q    <= 1'b0;
      hold_q   <= '0;
      rem_q    <= '0;
      load_q   <= '0;
      entry_q  <= '0;
      blocks_q <= '0;
    end else if (take_i) begin
      phase_q  <= phase_d;
      fmt_q    <= fmt_d;
      hold_q   <= hold_d;
      rem_q    <= rem_d;
      load_q   <= load_d;
      entry_q  <= entry_d;
      blocks_q <= blocks_d;
    end
  end

  assign blocks_ext = ExtW'(blocks_d);

  assign res_valid_o          = take_i && res_vld;
  assign res_o.result_kind    = res_kind;
  assign res_o.write_address  = res_addr;
  assign res_o.write_data     = res_data;
  assign res_o.exec_address   = res_exec_sel ? entry_d : 16'd0;
  assign res_o.format_kind    = fmt_d;
  assign res_o.error_code     = res_err;
  assign res_o.block_count    = blocks_ext[12:0];

  // A finish or an error always leaves the parser idle.
  a_end_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.result_kind != KindWrite |=> phase_q == PhIdle)
    else $error("parser not idle after a final result");

  a_blocks_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blocks_q <= CntW'(MAX_BLOCKS))
    else $error("block count above limit");

  a_hold_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take_i |=> $stable(phase_q) && $stable(blocks_q) && $stable(load_q))
    else $error("parser state changed without a request");

  a_write_format_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.result_kind == KindWrite |-> phase_q != PhIdle)
    else $error("write produced while idle");

endmodule

>>> rtl/binary_image_load_parser.sv
// ----------------------------------------------------------------------------
// Binary image load parser
// Parses a chunked or single-block image from a byte stream and emits memory
// writes, a finish with the entry address, or an error code.
// ----------------------------------------------------------------------------
//   Port group   Direction   Payload    Request moves
//   in_*         input       item_t     one file byte or end-of-file mark
//   out_*        output      result_t   one write, finish or error
//
// One request per cycle is sustained in both directions while out_* is not
// stalled. A result passes from in_* through the input register, the parser
// and the result register to out_*; each register holds one request. A stall
// on out_* backs up through both registers into in_ready_o. Reset leaves the
// parser idle, ignoring requests until one with new_file set; no clearing pass.
// ----------------------------------------------------------------------------
module binary_image_load_parser
  import bilp_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 4096
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  item_t   in_data_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_result_o
);

  logic    item_valid;
  item_t   item;
  logic    res_ready;
  logic    take;
  logic    res_valid;
  result_t res;

  bilp_stage #(
    .DATA_W($bits(item_t))
  ) u_in_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(in_valid_i),
    .ready_o(in_ready_o),
    .data_i (in_data_i),
    .valid_o(item_valid),
    .ready_i(take),
    .data_o (item)
  );

  // The parser advances only when the result register can take its output.
  assign take = item_valid && res_ready;

  bilp_parser #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .item_i     (item),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  bilp_stage #(
    .DATA_W($bits(result_t))
  ) u_out_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(res_valid),
    .ready_o(res_ready),
    .data_i (res),
    .valid_o(out_valid_o),
    .ready_i(out_ready_i),
    .data_o (out_result_o)
  );

endmodule
